// File: design/box_average_downscaler_top_defines.svh
// Assertion macros used by the box average downscaler top level
`ifndef BOX_AVERAGE_DOWNSCALER_TOP_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BOXDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BOXDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/boxds_pkg.sv
// Shared constants, types and reciprocal table of the box average downscaler
package boxds_pkg;

  // Size limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_FACTOR     = 8;

  // Field and register widths
  localparam int FCW         = 4;                        // factor register
  localparam int DIMW        = 11;                       // size register
  localparam int CHW         = 8;                        // one colour channel
  localparam int NCH         = 3;                        // channels per pixel
  localparam int SUMW        = 14;                       // channel accumulator
  localparam int COORDW      = 10;                       // output coordinate
  localparam int FBW         = $clog2(MAX_FACTOR);       // position inside block
  localparam int DIVW        = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int NDIV        = MAX_FACTOR * MAX_FACTOR;
  localparam int DIDXW       = $clog2(NDIV);
  localparam int RCPW        = 22;
  localparam int RCP_SHIFT   = 21;
  localparam int PRODW       = SUMW + RCPW;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FLD_W   = NCH * CHW + 2 * COORDW;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDXW    = 2;
  localparam int CFG_DATAW   = 11;

  // Register indexes
  typedef enum logic [CFG_IDXW-1:0] {
    REG_FACTOR_X     = 2'd0,
    REG_FACTOR_Y     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [FCW-1:0]  FACTOR_X_RST = 4'd4;
  localparam logic [FCW-1:0]  FACTOR_Y_RST = 4'd4;
  localparam logic [DIMW-1:0] WIDTH_RST    = 11'd320;
  localparam logic [DIMW-1:0] HEIGHT_RST   = 11'd240;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input request accepted this cycle
    logic acc;    // accumulate and write back the line store entry
    logic mul;    // multiply sums by reciprocal
    logic load;   // move quotient into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;      // current pixel closes a full block
    logic out_free;  // output register can take a new request
  } sts_t;

  // ceil(2^21 / d) for d = 1..64, entry d-1; exact floor for sums below 2^14
  localparam logic [RCPW-1:0] RECIP_TAB [NDIV] = '{
    22'd2097152, 22'd1048576, 22'd699051,  22'd524288,
    22'd419431,  22'd349526,  22'd299594,  22'd262144,
    22'd233017,  22'd209716,  22'd190651,  22'd174763,
    22'd161320,  22'd149797,  22'd139811,  22'd131072,
    22'd123362,  22'd116509,  22'd110377,  22'd104858,
    22'd99865,   22'd95326,   22'd91181,   22'd87382,
    22'd83887,   22'd80660,   22'd77673,   22'd74899,
    22'd72316,   22'd69906,   22'd67651,   22'd65536,
    22'd63551,   22'd61681,   22'd59919,   22'd58255,
    22'd56680,   22'd55189,   22'd53774,   22'd52429,
    22'd51151,   22'd49933,   22'd48771,   22'd47663,
    22'd46604,   22'd45591,   22'd44621,   22'd43691,
    22'd42800,   22'd41944,   22'd41121,   22'd40330,
    22'd39569,   22'd38837,   22'd38131,   22'd37450,
    22'd36793,   22'd36158,   22'd35545,   22'd34953,
    22'd34380,   22'd33826,   22'd33289,   22'd32768
  };

endpackage

// File: design/boxds_ctrl.sv
// Sequencing state machine of the box average downscaler
module boxds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  boxds_pkg::sts_t   sts,
  output boxds_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_MUL,
    S_LOAD
  } state_t;

  state_t state_r;

  // Commands decoded from state
  always_comb begin
    in_tready = (state_r == S_IDLE);
    cmd.take  = in_tready && in_tvalid;
    cmd.acc   = (state_r == S_ACC);
    cmd.mul   = (state_r == S_MUL);
    cmd.load  = (state_r == S_LOAD) && sts.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= sts.emit ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/boxds_dpath.sv
// Datapath: config registers, raster counters, line store, divide and output register
module boxds_dpath #(
  parameter int MAX_WIDTH  = boxds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = boxds_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  boxds_pkg::cmd_t                     cmd,
  output boxds_pkg::sts_t                     sts,
  input  logic                                cfg_we,
  input  logic [boxds_pkg::CFG_IDXW-1:0]      cfg_index,
  input  logic [boxds_pkg::CFG_DATAW-1:0]     cfg_data,
  input  logic [boxds_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [boxds_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int LIMW = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                        $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int DW   = ((LIMW > boxds_pkg::DIMW) ? LIMW : boxds_pkg::DIMW) + 2;
  localparam int SW   = boxds_pkg::SUMW;
  localparam int NCH  = boxds_pkg::NCH;
  localparam int CHW  = boxds_pkg::CHW;
  localparam int FCW  = boxds_pkg::FCW;
  localparam int FBW  = boxds_pkg::FBW;
  localparam int PAD  = boxds_pkg::OUT_TDATA_W - boxds_pkg::OUT_FLD_W;

  // Configuration registers
  logic [FCW-1:0]                 fx_r, fy_r;
  logic [boxds_pkg::DIMW-1:0]     width_r, height_r;

  // Raster position
  logic [CW-1:0]  in_col_r, in_col_nxt, bc_r, bc_nxt;
  logic [RW-1:0]  in_row_r, in_row_nxt, br_r, br_nxt;
  logic [FBW-1:0] cib_r, cib_nxt, rib_r, rib_nxt;

  // Pixel held through accumulate
  logic [CW-1:0]                   addr_q_r;
  logic [NCH*CHW-1:0]              pix_q_r;
  logic                            first_q_r, valid_q_r, emit_q_r, last_q_r;
  logic [boxds_pkg::COORDW-1:0]    col_q_r, row_q_r;
  logic [boxds_pkg::RCPW-1:0]      recip_q_r;

  // Line store of column sums
  logic [NCH*SW-1:0] mem [MAX_WIDTH];
  logic [NCH*SW-1:0] rd_r;
  logic [NCH*SW-1:0] sum_cat;
  logic [SW-1:0]     sum_r [NCH];
  logic [boxds_pkg::PRODW-1:0] prod_r [NCH];

  // Output register
  logic                                out_valid_r, out_last_r;
  logic [boxds_pkg::OUT_TDATA_W-1:0]   out_data_r;

  // Effective sizes after range limiting
  logic [FCW-1:0] fx_c, fy_c;
  logic [DW-1:0]  w_c, h_c, fx_d, fy_d;
  always_comb begin
    fx_c = fx_r;
    if (fx_r == '0) fx_c = FCW'(1);
    else if (fx_r > FCW'(boxds_pkg::MAX_FACTOR)) fx_c = FCW'(boxds_pkg::MAX_FACTOR);
    fy_c = fy_r;
    if (fy_r == '0) fy_c = FCW'(1);
    else if (fy_r > FCW'(boxds_pkg::MAX_FACTOR)) fy_c = FCW'(boxds_pkg::MAX_FACTOR);
    w_c = DW'(width_r);
    if (width_r == '0) w_c = DW'(1);
    else if (DW'(width_r) > DW'(MAX_WIDTH)) w_c = DW'(MAX_WIDTH);
    h_c = DW'(height_r);
    if (height_r == '0) h_c = DW'(1);
    else if (DW'(height_r) > DW'(MAX_HEIGHT)) h_c = DW'(MAX_HEIGHT);
    fx_d = DW'(fx_c);
    fy_d = DW'(fy_c);
  end

  // Block membership of the current pixel
  logic [DW-1:0] col_end, row_end;
  logic          valid_x, valid_y, last_x, last_y, first_now, close_now;
  logic [boxds_pkg::DIVW-1:0]  div;
  logic [boxds_pkg::DIDXW-1:0] div_idx;
  always_comb begin
    col_end   = DW'(in_col_r) - DW'(cib_r) + fx_d;
    row_end   = DW'(in_row_r) - DW'(rib_r) + fy_d;
    valid_x   = (col_end <= w_c);
    valid_y   = (row_end <= h_c);
    last_x    = ((col_end + fx_d) > w_c);
    last_y    = ((row_end + fy_d) > h_c);
    first_now = (cib_r == '0) && (rib_r == '0);
    close_now = (FCW'(cib_r) == fx_c - FCW'(1)) && (FCW'(rib_r) == fy_c - FCW'(1));
    div       = boxds_pkg::DIVW'(fx_c) * boxds_pkg::DIVW'(fy_c);
    div_idx   = boxds_pkg::DIDXW'(div - boxds_pkg::DIVW'(1));
  end

  // Next raster position
  logic cib_wrap, rib_wrap, line_end, frame_end;
  always_comb begin
    cib_wrap  = (FCW'(cib_r) + FCW'(1)) >= fx_c;
    rib_wrap  = (FCW'(rib_r) + FCW'(1)) >= fy_c;
    line_end  = (DW'(in_col_r) + DW'(1)) >= w_c;
    frame_end = (DW'(in_row_r) + DW'(1)) >= h_c;
    in_col_nxt = in_col_r + CW'(1);
    cib_nxt    = cib_wrap ? '0 : cib_r + FBW'(1);
    bc_nxt     = cib_wrap ? bc_r + CW'(1) : bc_r;
    in_row_nxt = in_row_r;
    rib_nxt    = rib_r;
    br_nxt     = br_r;
    if (line_end) begin
      in_col_nxt = '0;
      cib_nxt    = '0;
      bc_nxt     = '0;
      if (frame_end) begin
        in_row_nxt = '0;
        rib_nxt    = '0;
        br_nxt     = '0;
      end else begin
        in_row_nxt = in_row_r + RW'(1);
        rib_nxt    = rib_wrap ? '0 : rib_r + FBW'(1);
        br_nxt     = rib_wrap ? br_r + RW'(1) : br_r;
      end
    end
  end

  // Config registers and position counters; any write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r     <= boxds_pkg::FACTOR_X_RST;
      fy_r     <= boxds_pkg::FACTOR_Y_RST;
      width_r  <= boxds_pkg::WIDTH_RST;
      height_r <= boxds_pkg::HEIGHT_RST;
      in_col_r <= '0;
      in_row_r <= '0;
      bc_r     <= '0;
      br_r     <= '0;
      cib_r    <= '0;
      rib_r    <= '0;
    end else if (cfg_we) begin
      unique case (boxds_pkg::cfg_reg_t'(cfg_index))
        boxds_pkg::REG_FACTOR_X:     fx_r     <= cfg_data[FCW-1:0];
        boxds_pkg::REG_FACTOR_Y:     fy_r     <= cfg_data[FCW-1:0];
        boxds_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[boxds_pkg::DIMW-1:0];
        boxds_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[boxds_pkg::DIMW-1:0];
        default: ;
      endcase
      in_col_r <= '0;
      in_row_r <= '0;
      bc_r     <= '0;
      br_r     <= '0;
      cib_r    <= '0;
      rib_r    <= '0;
    end else if (cmd.take) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      bc_r     <= bc_nxt;
      br_r     <= br_nxt;
      cib_r    <= cib_nxt;
      rib_r    <= rib_nxt;
    end
  end

  // Capture the accepted pixel and its block facts
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      addr_q_r  <= bc_r;
      pix_q_r   <= in_tdata[NCH*CHW-1:0];
      first_q_r <= first_now;
      valid_q_r <= valid_x && valid_y;
      emit_q_r  <= valid_x && valid_y && close_now;
      last_q_r  <= last_x && last_y;
      col_q_r   <= boxds_pkg::COORDW'(bc_r);
      row_q_r   <= boxds_pkg::COORDW'(br_r);
      recip_q_r <= boxds_pkg::RECIP_TAB[div_idx];
    end
  end

  // New sums: first pixel of a block overwrites the entry
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      sum_cat[i*SW +: SW] = first_q_r ? SW'(pix_q_r[i*CHW +: CHW]) :
                            rd_r[i*SW +: SW] + SW'(pix_q_r[i*CHW +: CHW]);
    end
  end

  // Line store: read on accept, write back during accumulate
  always_ff @(posedge clk) begin
    if (cmd.take) rd_r <= mem[bc_r];
    if (cmd.acc && valid_q_r) mem[addr_q_r] <= sum_cat;
  end

  // Sum and product stages
  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      if (cmd.acc) sum_r[i] <= sum_cat[i*SW +: SW];
      if (cmd.mul) prod_r[i] <= boxds_pkg::PRODW'(sum_r[i]) *
                                boxds_pkg::PRODW'(recip_q_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {{PAD{1'b0}}, row_q_r, col_q_r,
                     prod_r[2][boxds_pkg::RCP_SHIFT +: CHW],
                     prod_r[1][boxds_pkg::RCP_SHIFT +: CHW],
                     prod_r[0][boxds_pkg::RCP_SHIFT +: CHW]};
      out_last_r <= last_q_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign sts.emit     = emit_q_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// File: design/box_average_downscaler_top.sv
// Top level of the box average downscaler
//
// Takes a raster-order stream of three-channel 8-bit pixels on the in_ channel
// and returns one averaged pixel per full factor_x by factor_y block on the
// out_ channel, in block order, with its block column and row. out_tlast marks
// the last block of a frame. Pixels of partial blocks at the right or bottom
// edge give no request. Writes on the cfg_ port set the factors and the image
// size and restart the frame at column 0, row 0; write only while idle.
// Each accepted pixel goes through the read-modify-write of its line store
// entry; a pixel that closes a block then also goes through a multiply by a
// reciprocal from a 64-entry table and a load into the output register.
// The block waits for the read-modify-write loop on the single-port line
// store to finish before it accepts the next pixel.
// The output register lets the next pixel be accepted while a result waits;
// if the receiver still holds off when the following result is ready, input
// stalls until out_tready. Reset (synchronous, rst_n low) restores the
// register defaults, empties the output and restarts the frame; the line store
// needs no clearing pass, since the first pixel of a block overwrites it.
`include "box_average_downscaler_top_defines.svh"

module box_average_downscaler_top #(
  parameter int MAX_WIDTH  = boxds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = boxds_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // chan0_in[7:0], chan1_in[15:8], chan2_in[23:16]
  input  logic [boxds_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // chan0_avg[7:0], chan1_avg[15:8], chan2_avg[23:16], out_col[33:24],
  // out_row[43:34], zero pad[47:44]
  output logic [boxds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [boxds_pkg::CFG_IDXW-1:0]     cfg_index,
  input  logic [boxds_pkg::CFG_DATAW-1:0]    cfg_data
);

  boxds_pkg::cmd_t cmd;
  boxds_pkg::sts_t sts;

  // Controller
  boxds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  boxds_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // One pixel in flight: no accept in the cycle after an accept
  `BOXDS_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second accept")

  // A new result only comes out of the load step, never while idle
  `BOXDS_ASSERT_NOW(a_load_not_idle, $rose(out_tvalid), !$past(in_tready), "stray result")

  // Accumulate never loads the output in the very next cycle
  `BOXDS_ASSERT_NEXT(a_no_early_out, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "early result")

endmodule
